[hdl/awo_pkg.sv]
// ============================================================================
// awo_pkg
// Shared constants, controller/datapath interface types and the sine ROM
// contents for the additive waveform oscillator.
// ============================================================================
`default_nettype none

package awo_pkg;

    localparam int MAX_HARMONICS    = 64;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_BITS      = 16;

    localparam int ROM_AW = $clog2(SINE_TABLE_DEPTH);     // ROM address bits
    localparam int M_W    = $clog2(2 * MAX_HARMONICS);    // harmonic multiple bits
    localparam int CNT_W  = $clog2(MAX_HARMONICS + 1);    // term counter bits
    localparam int ACC_W  = 34;                           // series accumulator
    localparam int SMP_W  = 35;                           // scaled Q5.30 sample

    localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;
    localparam logic [30:0] FOUR_OVER_PI_Q30 = 31'd1367130551;
    localparam logic [30:0] TWO_OVER_PI_Q30  = 31'd683565276;

    // waveform codes; code 3 also plays the sawtooth series
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd2;
    localparam logic [1:0] WAVE_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        CFG_WAVEFORM    = 3'd0,
        CFG_HARMONICS   = 3'd1,
        CFG_VOLUME      = 3'd2,
        CFG_LEFT_GAIN   = 3'd3,
        CFG_TARGET_STEP = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic start;        // item taken, block_start below is valid
        logic block_start;
        logic phase;        // advance phase, set up series
        logic issue;        // push one harmonic term into the pipe
        logic scale;        // series sum times 4/pi or 2/pi
        logic vol;          // volume multiply
        logic gain;         // gain multiply
        logic load_out;     // saturate into output register
    } t_dp_cmd;

    typedef struct packed {
        logic busy;         // term pipe still holds work
    } t_dp_status;

    // sin(2*pi*i/DEPTH) in Q2.30, Taylor series over the first quadrant
    function automatic logic signed [31:0] rom_entry(int unsigned i);
        logic [63:0]        quarter;
        logic [63:0]        rem;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        quarter = (64'(i) * 64'd4) / SINE_TABLE_DEPTH;
        rem     = (64'(i) * 64'd4) % SINE_TABLE_DEPTH;
        x       = (rem * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        if (quarter[0]) begin
            x = HALF_PI_Q30 - x;
        end
        x2   = (x * x) >> 30;
        term = x;
        s    = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   s = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  s = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  s = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  s = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; s = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; s = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; s = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd272; s = s + $signed(term);
        if (quarter[1]) begin
            s = -s;
        end
        return s[31:0];
    endfunction

endpackage

`default_nettype wire

[hdl/awo_ctrl.sv]
// ============================================================================
// awo_ctrl
// Sequencer: takes an item, runs the harmonic series through the datapath,
// then the scaling steps, and hands the sample to the output register.
// ============================================================================
`default_nettype none

module awo_ctrl
    import awo_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_block_start,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_waveform,
    input  wire logic [6:0]  i_harmonic_count,
    output t_dp_cmd          o_cmd,
    input  wire t_dp_status  i_status
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PHASE = 8'b0000_0010,
        S_TERMS = 8'b0000_0100,
        S_DRAIN = 8'b0000_1000,
        S_SCALE = 8'b0001_0000,
        S_VOL   = 8'b0010_0000,
        S_GAIN  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   n_clamp;
    logic [CNT_W-1:0]   n_total;
    logic               accept;
    logic               load_out;

    // terms in this series
    always_comb begin
        n_clamp = (int'(i_harmonic_count) > MAX_HARMONICS) ? CNT_W'(MAX_HARMONICS)
                                                           : CNT_W'(i_harmonic_count);
        priority if (i_waveform == WAVE_SINE) begin
            n_total = CNT_W'(1);
        end else if (i_waveform == WAVE_SQUARE) begin
            n_total = n_clamp;
        end else begin
            n_total = (n_clamp == '0) ? '0 : n_clamp - 1'b1;
        end
    end

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign load_out = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PHASE;
                end
            end
            S_PHASE: begin
                n_cnt   = '0;
                n_state = (n_total == '0) ? S_DRAIN : S_TERMS;
            end
            S_TERMS: begin
                if (r_cnt == n_total - 1'b1) begin
                    n_state = S_DRAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_VOL;
            S_VOL:   n_state = S_GAIN;
            S_GAIN:  n_state = S_OUT;
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.start       = accept;
        o_cmd.block_start = i_block_start;
        o_cmd.phase       = (r_state == S_PHASE);
        o_cmd.issue       = (r_state == S_TERMS);
        o_cmd.scale       = (r_state == S_SCALE);
        o_cmd.vol         = (r_state == S_VOL);
        o_cmd.gain        = (r_state == S_GAIN);
        o_cmd.load_out    = load_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TERMS) |-> (r_cnt < n_total))
        else $error("term counter ran past series length");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled output item dropped");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_PHASE))
        else $error("accepted item did not start a sample");

    a_drain_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DRAIN) && i_status.busy) |=> (r_state == S_DRAIN))
        else $error("scaling started while terms still in flight");

endmodule

`default_nettype wire

[hdl/awo_datapath.sv]
// ============================================================================
// awo_datapath
// Phase accumulator, sine ROM, per-term divide pipe, series accumulator and
// the scale / volume / gain / saturate steps.
// ============================================================================
`default_nettype none

module awo_datapath
    import awo_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_dp_cmd      i_cmd,
    output t_dp_status        o_status,
    input  wire logic [1:0]   i_waveform,
    input  wire logic [15:0]  i_volume,
    input  wire logic [15:0]  i_left_gain,
    input  wire logic [31:0]  i_target_step,
    output logic signed [15:0] o_sample
);

    localparam int RC_DEPTH = 2 ** M_W;
    localparam int Y3_W     = 39 - (31 - SAMPLE_BITS);

    // sine ROM and reciprocal table, both built at elaboration
    logic signed [31:0] rom_tab [SINE_TABLE_DEPTH];
    logic [31:0]        rc_tab  [RC_DEPTH];

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic signed [31:0] ENTRY = rom_entry(gi);
        assign rom_tab[gi] = ENTRY;
    end

    // floor(2^32/m); m of one bypasses the multiply
    for (genvar gm = 0; gm < RC_DEPTH; gm++) begin : g_rc
        localparam logic [31:0] RC = (gm < 2) ? 32'd0
                                   : 32'((64'd1 << 32) / ((gm < 2) ? 2 : gm));
        assign rc_tab[gm] = RC;
    end

    logic is_sine;
    logic is_square;
    assign is_sine   = (i_waveform == WAVE_SINE);
    assign is_square = (i_waveform == WAVE_SQUARE);

    // phase state
    logic [31:0]      r_step;
    logic [31:0]      r_phase;
    logic [31:0]      n_phase;
    logic [33:0]      step_mix;
    logic [31:0]      r_hp;
    logic [31:0]      r_hinc;
    logic [M_W-1:0]   r_m;

    assign step_mix = {r_step, 1'b0} + {2'b00, r_step} + {2'b00, i_target_step};
    assign n_phase  = r_phase + r_step;

    // term pipe
    logic               r_v1, r_v2, r_v3;
    logic signed [31:0] r_rom;
    logic [M_W-1:0]     r_m1, r_m2;
    logic               r_sub1, r_neg2, r_neg3;
    logic [30:0]        r_abs2, r_q0, r_q;
    logic [31:0]        abs1;
    logic [62:0]        recip_prod;
    logic [30:0]        q0;
    logic [37:0]        qm;
    logic [37:0]        rem;
    logic [30:0]        q_fix;

    assign abs1       = r_rom[31] ? 32'(-r_rom) : 32'(r_rom);
    assign recip_prod = abs1[30:0] * rc_tab[r_m1];
    assign q0         = (r_m1 == M_W'(1)) ? abs1[30:0] : recip_prod[62:32];
    assign qm         = r_q0 * r_m2;
    assign rem        = 38'(r_abs2) - qm;
    assign q_fix      = (rem >= 38'(r_m2)) ? r_q0 + 1'b1 : r_q0;

    // series sum and scaling
    logic signed [ACC_W-1:0] r_acc;
    logic signed [65:0]      r_prod;
    logic signed [SMP_W-1:0] sample;
    logic signed [51:0]      vol_prod;
    logic signed [36:0]      r_y1;
    logic signed [53:0]      gain_prod;
    logic signed [38:0]      r_y2;
    logic signed [Y3_W-1:0]  y3;
    logic signed [Y3_W-1:0]  sat_max;
    logic signed [Y3_W-1:0]  sat_min;
    logic [SAMPLE_BITS-1:0]  sat_val;
    logic [15:0]             aligned;
    logic [15:0]             r_out;

    assign sample    = is_sine ? SMP_W'(r_acc) : r_prod[SMP_W+29:30];
    assign vol_prod  = sample * $signed({1'b0, i_volume});
    assign gain_prod = r_y1 * $signed({1'b0, i_left_gain});
    assign y3        = r_y2[38:31-SAMPLE_BITS];
    assign sat_max   = $signed({{(Y3_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    assign sat_min   = ~sat_max;

    always_comb begin
        priority if (y3 > sat_max) begin
            sat_val = sat_max[SAMPLE_BITS-1:0];
        end else if (y3 < sat_min) begin
            sat_val = sat_min[SAMPLE_BITS-1:0];
        end else begin
            sat_val = y3[SAMPLE_BITS-1:0];
        end
    end

    if (SAMPLE_BITS >= 16) begin : g_align_dn
        assign aligned = sat_val[SAMPLE_BITS-1 -: 16];
    end else begin : g_align_up
        assign aligned = {sat_val, {(16-SAMPLE_BITS){1'b0}}};
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_phase <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            if (i_cmd.start && i_cmd.block_start) begin
                r_step <= step_mix[33:2];
            end
            if (i_cmd.phase) begin
                r_phase <= n_phase;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.phase) begin
            r_hp   <= n_phase;
            r_hinc <= is_square ? {n_phase[30:0], 1'b0} : n_phase;
            r_m    <= M_W'(1);
            r_acc  <= '0;
        end
        if (i_cmd.issue) begin
            r_rom  <= rom_tab[r_hp[31 -: ROM_AW]];
            r_m1   <= r_m;
            r_sub1 <= !is_sine && !is_square && r_m[0];
            r_hp   <= r_hp + r_hinc;
            r_m    <= r_m + (is_square ? M_W'(2) : M_W'(1));
        end
        r_abs2 <= abs1[30:0];
        r_q0   <= q0;
        r_m2   <= r_m1;
        r_neg2 <= r_rom[31] ^ r_sub1;
        r_q    <= q_fix;
        r_neg3 <= r_neg2;
        if (r_v3) begin
            r_acc <= r_neg3 ? r_acc - ACC_W'(r_q) : r_acc + ACC_W'(r_q);
        end
        if (i_cmd.scale) begin
            r_prod <= r_acc * $signed({1'b0, is_square ? FOUR_OVER_PI_Q30
                                                       : TWO_OVER_PI_Q30});
        end
        if (i_cmd.vol) begin
            r_y1 <= vol_prod[51:15];
        end
        if (i_cmd.gain) begin
            r_y2 <= gain_prod[53:15];
        end
        if (i_cmd.load_out) begin
            r_out <= aligned;
        end
    end

    assign o_status.busy = r_v1 || r_v2 || r_v3;
    assign o_sample      = $signed(r_out);

endmodule

`default_nettype wire

[hdl/additive_waveform_oscillator.sv]
// ============================================================================
// additive_waveform_oscillator
// Band-limited tone generator: sine, square series or sawtooth series,
// scaled by volume and gain, one stereo sample per input tick.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one tick per item; set
//   i_block_start on the first tick of a buffer to glide the phase step a
//   quarter of the way toward target_step. Output channel (o_out_valid /
//   i_out_stall) returns one sample item per tick, same value on both sides.
//   Each item sums N harmonic terms (1 for sine, min(count,64) for square,
//   that minus one for sawtooth) in the single shared ROM read and divide
//   pipe, one term per cycle, then waits for the pipe to drain before the
//   scale, volume and gain steps. No new tick is taken until the sample is
//   loaded into the output register.
//   The finished sample sits in an output register; the next tick is taken
//   while it waits, and the new sample is held back only if the old one is
//   still stalled when it is ready.
//   Reset (i_rst_n low, synchronous) clears phase, step and the handshake,
//   and loads register defaults: sine, 10 harmonics, volume 3277, gain 0.5.
//   Config writes (i_cfg_we) take effect at once; write only while idle.
// ============================================================================
`default_nettype none

module additive_waveform_oscillator
    import awo_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // tick input
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic         i_block_start,
    // sample output
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample,
    // configuration
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);

    logic [1:0]   r_waveform;
    logic [6:0]   r_harmonic_count;
    logic [15:0]  r_volume;
    logic [15:0]  r_left_gain;
    logic [31:0]  r_target_step;

    // register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform       <= WAVE_SINE;
            r_harmonic_count <= 7'd10;
            r_volume         <= 16'd3277;
            r_left_gain      <= 16'd16384;
            r_target_step    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAVEFORM:    r_waveform       <= i_cfg_data[1:0];
                CFG_HARMONICS:   r_harmonic_count <= i_cfg_data[6:0];
                CFG_VOLUME:      r_volume         <= i_cfg_data[15:0];
                CFG_LEFT_GAIN:   r_left_gain      <= i_cfg_data[15:0];
                CFG_TARGET_STEP: r_target_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic signed [15:0] sample;

    // sequencer
    awo_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_block_start    (i_block_start),
        .o_in_stall       (o_in_stall),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_waveform       (r_waveform),
        .i_harmonic_count (r_harmonic_count),
        .o_cmd            (cmd),
        .i_status         (status)
    );

    // phase, ROM, term pipe and scaling
    awo_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_waveform    (r_waveform),
        .i_volume      (r_volume),
        .i_left_gain   (r_left_gain),
        .i_target_step (r_target_step),
        .o_sample      (sample)
    );

    // pan gain is shared, so both channels carry the same value
    assign o_left_sample  = sample;
    assign o_right_sample = sample;

endmodule

`default_nettype wire

[verif/testbench.sv]
// ============================================================================
// testbench
// Self-checking bench for additive_waveform_oscillator: ticks go in over the
// valid/stall channel and every sample that comes back is compared with a
// bit-true fixed-point model of the oscillator kept inside the bench. Runs a
// directed sweep of the corner settings, then randomized buffers under many
// register settings, with random idling and backpressure on both channels.
// ============================================================================
module testbench;
    import awo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 20000;              // cycles with no handshake
    localparam int SETTLE_CYCLES = MAX_HARMONICS + 16; // beyond worst tick latency
    localparam int RANDOM_PHASES = 20;
    localparam int HOLD_CYCLES   = 400;                // long output hold-off

    // raw register data, upper bits beyond each register's width included
    typedef struct {
        logic [31:0] wave;
        logic [31:0] harmonics;
        logic [31:0] volume;
        logic [31:0] gain;
        logic [31:0] target;
    } t_tone_setting;

    // ------------------------------------------------------------------------
    // Sample scoreboard: tracks phase, smoothed step and registers, computes
    // the sample each accepted tick must produce and checks returned samples
    // in order.
    // ------------------------------------------------------------------------
    class sample_scoreboard;
        logic signed [31:0] sine_table[SINE_TABLE_DEPTH];
        logic signed [15:0] expected_samples[$];
        logic [1:0]         wave;
        logic [6:0]         harmonics;
        logic [15:0]        volume;
        logic [15:0]        gain;
        logic [31:0]        target_step;
        logic [31:0]        tone_phase;
        logic [31:0]        tone_step;
        int                 errors;
        int                 checked;
        int                 clipped;
        int                 ticks_per_wave[4];

        // quarter-wave Taylor series, mirrored into a full-turn Q2.30 table
        function new();
            longint unsigned quarter;
            longint unsigned rem;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          s;
            int              i;
            int              n;
            for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
                quarter = (64'(i) * 4) / SINE_TABLE_DEPTH;
                rem     = (64'(i) * 4) % SINE_TABLE_DEPTH;
                x       = (rem * HALF_PI_Q30) / SINE_TABLE_DEPTH;
                if (quarter[0]) begin
                    x = HALF_PI_Q30 - x;
                end
                x2   = (x * x) >> 30;
                term = x;
                s    = longint'(x);
                for (n = 1; n <= 8; n++) begin
                    term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
                    if (n % 2 == 1) begin
                        s -= longint'(term);
                    end else begin
                        s += longint'(term);
                    end
                end
                if (quarter[1]) begin
                    s = -s;
                end
                sine_table[i] = s[31:0];
            end
            wave        = WAVE_SINE;
            harmonics   = 7'd10;
            volume      = 16'd3277;
            gain        = 16'd16384;
            target_step = '0;
            tone_phase  = '0;
            tone_step   = '0;
        endfunction

        function longint sine_at(logic [31:0] ph);
            longint unsigned idx;
            idx = (64'(ph) * SINE_TABLE_DEPTH) >> 32;
            if (idx >= SINE_TABLE_DEPTH) begin
                idx = SINE_TABLE_DEPTH - 1;
            end
            return longint'(sine_table[idx]);
        endfunction

        // unknown indexes fall through and change nothing
        function void set_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_WAVEFORM:    wave        = data[1:0];
                CFG_HARMONICS:   harmonics   = data[6:0];
                CFG_VOLUME:      volume      = data[15:0];
                CFG_LEFT_GAIN:   gain        = data[15:0];
                CFG_TARGET_STEP: target_step = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        // one accepted tick: glide step, advance phase, build the sample
        function void take_tick(logic block_start);
            logic [33:0] blend;
            longint      n;
            longint      k;
            longint      acc;
            longint      term;
            longint      smp;
            longint      y;
            longint      lim;
            if (block_start) begin
                blend     = 34'(tone_step) * 3 + 34'(target_step);
                tone_step = blend[33:2];
            end
            tone_phase = tone_phase + tone_step;
            n   = (harmonics > MAX_HARMONICS) ? MAX_HARMONICS : harmonics;
            acc = 0;
            if (wave == WAVE_SINE) begin
                smp = sine_at(tone_phase);
            end else if (wave == WAVE_SQUARE) begin
                // odd harmonics only, each scaled by 1/m, truncated
                for (k = 0; k < n; k++) begin
                    acc += sine_at(32'((2 * k + 1) * tone_phase)) / (2 * k + 1);
                end
                smp = (acc * longint'(FOUR_OVER_PI_Q30)) >>> 30;
            end else begin
                // sawtooth; code 3 lands here too. Odd terms subtract.
                for (k = 1; k < n; k++) begin
                    term = sine_at(32'(k * tone_phase)) / k;
                    if (k % 2 == 1) begin
                        acc -= term;
                    end else begin
                        acc += term;
                    end
                end
                smp = (acc * longint'(TWO_OVER_PI_Q30)) >>> 30;
            end
            y   = (smp * longint'(volume)) >>> 15;
            y   = (y * longint'(gain)) >>> 15;
            y   = y >>> (31 - SAMPLE_BITS);
            lim = longint'(1) <<< (SAMPLE_BITS - 1);
            if (y > lim - 1) begin
                y = lim - 1;
                clipped++;
            end else if (y < -lim) begin
                y = -lim;
                clipped++;
            end
            if (SAMPLE_BITS >= 16) begin
                y = y >>> (SAMPLE_BITS - 16);
            end else begin
                y = y <<< (16 - SAMPLE_BITS);
            end
            ticks_per_wave[wave]++;
            expected_samples.push_back(y[15:0]);
        endfunction

        function void check_sample(logic signed [15:0] left_got,
                                   logic signed [15:0] right_got);
            logic signed [15:0] want;
            if (expected_samples.size() == 0) begin
                errors++;
                $display("%0t: sample with no tick pending, left %0d right %0d",
                         $time, left_got, right_got);
            end else begin
                want = expected_samples.pop_front();
                checked++;
                if (left_got !== want) begin
                    errors++;
                    $display("%0t: left sample expected %0d, got %0d",
                             $time, want, left_got);
                end
                if (right_got !== want) begin
                    errors++;
                    $display("%0t: right sample expected %0d, got %0d",
                             $time, want, right_got);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic               i_block_start = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic signed [15:0] o_left_sample;
    logic signed [15:0] o_right_sample;
    logic               i_cfg_we      = 1'b0;
    logic [2:0]         i_cfg_index   = '0;
    logic [31:0]        i_cfg_data    = '0;

    sample_scoreboard tone_board;

    // idling controls, set by the stimulus and read by the drivers
    bit tx_bursts   = 1'b1;
    bit rx_bursts   = 1'b1;
    int rx_hold_len = 0;
    int settings_done = 0;
    int ticks_sent    = 0;

    additive_waveform_oscillator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_block_start  (i_block_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_sample  (o_left_sample),
        .o_right_sample (o_right_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Monitor: both handshakes sampled at the edge, before any NBA lands,
    // so the values seen are the ones the DUT acted on.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                tone_board.take_tick(i_block_start);
                ticks_sent++;
            end
            if (o_out_valid && !i_out_stall) begin
                tone_board.check_sample(o_left_sample, o_right_sample);
            end
        end
    end

    // Output side: random stall bursts, plus one long hold-off on request
    // that lets the block back up into its input.
    initial begin : sample_sink
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
                i_out_stall <= 1'b0;
            end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no handshake for %0d cycles, %0d samples outstanding",
                 $time, QUIET_LIMIT, tone_board.pending());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One tick; valid stays high afterwards so back-to-back ticks never
    // drop it; an idle gap in the next call or a drain lowers it.
    task automatic send_tick(logic bs);
        if (tx_bursts && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_block_start <= bs;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop offering and wait for every outstanding sample
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tone_board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // we stays high across a run of writes; program_tone lowers it
    task automatic put_register(logic [2:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tone_board.set_register(idx, data);
    endtask

    task automatic program_tone(t_tone_setting t, bit stray);
        put_register(CFG_WAVEFORM, t.wave);
        put_register(CFG_HARMONICS, t.harmonics);
        put_register(CFG_VOLUME, t.volume);
        put_register(CFG_LEFT_GAIN, t.gain);
        put_register(CFG_TARGET_STEP, t.target);
        // writes to indexes past the register list must be dropped
        if (stray) begin
            for (int ix = int'(CFG_TARGET_STEP) + 1; ix < 2 ** $bits(i_cfg_index); ix++) begin
                put_register(3'(ix), $urandom());
            end
        end
        i_cfg_we <= 1'b0;
        settings_done++;
    endtask

    // Buffers of 1..16 ticks led by block_start; some lose their start flag
    // and a few carry a stray start in the middle.
    task automatic play_buffers(int n_ticks);
        int remaining;
        logic bs;
        remaining = 0;
        repeat (n_ticks) begin
            if (remaining == 0) begin
                remaining = $urandom_range(1, 16);
                bs = ($urandom_range(0, 9) != 0);
            end else begin
                bs = ($urandom_range(0, 19) == 0);
            end
            remaining--;
            send_tick(bs);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_tone_setting tone;
        int p;
        tone_board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: step stays zero, so phase and sample sit at zero
        send_tick(1'b0);
        send_tick(1'b1);
        drain();

        // Full-scale sine, step gliding toward a quarter turn
        program_tone('{32'(WAVE_SINE), 32'd10, 32'd32768, 32'd32768, 32'h4000_0000}, 1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        drain();

        // Square with no terms gives silence
        program_tone('{32'(WAVE_SQUARE), 32'd0, 32'd32768, 32'd32768, 32'h0800_0000}, 1'b0);
        send_tick(1'b1);
        drain();

        // Square with every term, largest gains, largest step: clips both ways
        program_tone('{32'(WAVE_SQUARE), 32'(MAX_HARMONICS), 32'hFFFF, 32'hFFFF,
                       32'hFFFF_FFFF}, 1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();

        // Sawtooth with a single term sums nothing
        program_tone('{32'(WAVE_SAWTOOTH), 32'd1, 32'd32768, 32'd32768, 32'h1000_0000},
                     1'b0);
        send_tick(1'b1);
        drain();

        // Unused waveform code, term count beyond the maximum (clamped)
        program_tone('{32'(WAVE_RESERVED), 32'd127, 32'd32768, 32'd32768, 32'h1234_5678},
                     1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain();

        // Zero volume and gain, plus writes to unused indexes
        program_tone('{32'(WAVE_SINE), 32'd0, 32'd0, 32'd0, 32'h0100_0000}, 1'b1);
        send_tick(1'b1);
        drain();

        // Sawtooth with a harmonic count of two (one term summed) at a half-turn target, gain above one
        program_tone('{32'(WAVE_SAWTOOTH), 32'd2, 32'hFFFF, 32'hFFFF, 32'h8000_0000}, 1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        // Random settings, each followed by a run of buffers. The last few
        // phases run with no idling on either side.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            tx_bursts = (p < RANDOM_PHASES - 3) && ($urandom_range(0, 3) != 0);
            rx_bursts = (p < RANDOM_PHASES - 3) && ($urandom_range(0, 3) != 0);

            tone.wave      = $urandom();
            tone.wave[1:0] = 2'($urandom_range(0, 3));

            // mostly short series to keep the run brisk
            tone.harmonics = $urandom();
            case ($urandom_range(0, 9))
                0:       tone.harmonics[6:0] = 7'd0;
                1:       tone.harmonics[6:0] = 7'd1;
                2:       tone.harmonics[6:0] = 7'd2;
                3:       tone.harmonics[6:0] = 7'(MAX_HARMONICS);
                4:       tone.harmonics[6:0] = 7'($urandom_range(MAX_HARMONICS + 1, 127));
                default: tone.harmonics[6:0] = 7'($urandom_range(3, 16));
            endcase

            tone.volume = $urandom();
            case ($urandom_range(0, 5))
                0:       tone.volume[15:0] = 16'd0;
                1:       tone.volume[15:0] = 16'd32768;
                2:       tone.volume[15:0] = 16'hFFFF;
                default: tone.volume[15:0] = 16'($urandom_range(0, 32768));
            endcase

            tone.gain = $urandom();
            case ($urandom_range(0, 5))
                0:       tone.gain[15:0] = 16'd0;
                1:       tone.gain[15:0] = 16'd32768;
                2:       tone.gain[15:0] = 16'hFFFF;
                default: tone.gain[15:0] = 16'($urandom_range(0, 32768));
            endcase

            case ($urandom_range(0, 5))
                0:       tone.target = 32'd0;
                1:       tone.target = 32'hFFFF_FFFF;
                2:       tone.target = $urandom_range(1, 1 << 20);
                default: tone.target = $urandom();
            endcase

            program_tone(tone, $urandom_range(0, 4) == 0);

            // halfway through, hold the output long enough to back up input
            if (p == RANDOM_PHASES / 2) begin
                rx_hold_len = HOLD_CYCLES;
            end
            play_buffers($urandom_range(60, 140));
            drain();
        end

        // catch any sample the block sends without a tick behind it, and any that never arrives
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tone_board.pending() != 0) begin
            $display("%0t: %0d samples never arrived", $time, tone_board.pending());
        end

        $display("Sent %0d ticks under %0d register settings: sine %0d, square %0d, sawtooth %0d",
                 ticks_sent, settings_done, tone_board.ticks_per_wave[WAVE_SINE],
                 tone_board.ticks_per_wave[WAVE_SQUARE],
                 tone_board.ticks_per_wave[WAVE_SAWTOOTH]
                 + tone_board.ticks_per_wave[WAVE_RESERVED]);
        $display("Checked %0d samples, %0d at the clip limit, %0d mismatches",
                 tone_board.checked, tone_board.clipped, tone_board.errors);
        if (tone_board.errors == 0 && tone_board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
